[rtl/dsfr_pkg.sv]
// shared types and constants for the dle/stx frame receiver
// no dependencies; used by every module of the block except dsfr_ram
package dsfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_END    = CFG_IDX_W'(2);

    // reset values of the control codes
    localparam logic [BYTE_W-1:0] ESCAPE_RST = BYTE_W'(16);
    localparam logic [BYTE_W-1:0] START_RST  = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] END_RST    = BYTE_W'(3);

    typedef enum logic [2:0] {
        RX_IDLE       = 3'd0,
        RX_WAIT_START = 3'd1,
        RX_DATA       = 3'd2,
        RX_ESCAPE     = 3'd3,
        RX_WAIT_CHECK = 3'd4
    } rx_phase_t;

    typedef enum logic {
        RD_IDLE  = 1'b0,
        RD_FETCH = 1'b1
    } rd_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } rd_start_t;

    typedef struct packed {
        logic busy;
    } rd_status_t;

endpackage

[rtl/dsfr_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module dsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/dsfr_rx_fsm.sv]
// receive state machine: escape decoding, check accumulation, payload writes
// depends on dsfr_pkg
module dsfr_rx_fsm (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [dsfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [dsfr_pkg::BYTE_W-1:0] escape_code,
    input  logic [dsfr_pkg::BYTE_W-1:0] start_code,
    input  logic [dsfr_pkg::BYTE_W-1:0] end_code,
    output dsfr_pkg::ram_wr_t          ram_wr,
    output dsfr_pkg::rd_start_t        rd_start
);
    import dsfr_pkg::*;

    rx_phase_t         phase_reg, phase_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              room;

    assign room = (cnt_reg != CNT_W'(MAX_PAYLOAD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= RX_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next phase
    always_comb begin
        phase_next = RX_IDLE;
        unique case (phase_reg)
            RX_IDLE: begin
                phase_next = (rx_byte == escape_code) ? RX_WAIT_START : RX_IDLE;
            end
            RX_WAIT_START: begin
                phase_next = (rx_byte == start_code) ? RX_DATA : RX_IDLE;
            end
            RX_DATA: begin
                priority if (rx_byte == escape_code) begin
                    phase_next = RX_ESCAPE;
                end else if (room) begin
                    phase_next = RX_DATA;
                end else begin
                    phase_next = RX_IDLE;
                end
            end
            RX_ESCAPE: begin
                priority if (rx_byte == escape_code) begin
                    phase_next = room ? RX_DATA : RX_IDLE;
                end else if (rx_byte == end_code) begin
                    phase_next = RX_WAIT_CHECK;
                end else if (rx_byte == start_code) begin
                    phase_next = RX_DATA;
                end else begin
                    phase_next = RX_IDLE;
                end
            end
            RX_WAIT_CHECK: begin
                phase_next = RX_IDLE;
            end
            default: begin
                phase_next = RX_IDLE;
            end
        endcase
    end

    // accumulator, count, store write and readout start
    always_comb begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ram_wr.wr_en   = 1'b0;
        ram_wr.addr    = cnt_reg[ADDR_W-1:0];
        ram_wr.data    = rx_byte;
        rd_start.start = 1'b0;
        rd_start.count = cnt_reg;
        unique case (phase_reg)
            RX_IDLE: begin
                acc_next = '0;
                cnt_next = '0;
            end
            RX_WAIT_START: begin
            end
            RX_DATA: begin
                priority if (rx_byte == escape_code) begin
                end else if (room) begin
                    ram_wr.wr_en = accept;
                    acc_next     = acc_reg ^ rx_byte;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end else begin
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            RX_ESCAPE: begin
                priority if (rx_byte == escape_code) begin
                    if (room) begin
                        ram_wr.wr_en = accept;
                        acc_next     = acc_reg ^ rx_byte;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end else begin
                        acc_next = '0;
                        cnt_next = '0;
                    end
                end else if (rx_byte == end_code) begin
                    acc_next = acc_reg ^ rx_byte;
                end else begin
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            RX_WAIT_CHECK: begin
                rd_start.start = accept && (rx_byte == acc_reg) && (cnt_reg != '0);
                acc_next       = '0;
                cnt_next       = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/dsfr_readout.sv]
// readout of a checked frame from the payload store into the output register
// depends on dsfr_pkg
module dsfr_readout (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dsfr_pkg::rd_start_t         rd_start,
    output logic                        ram_rd_en,
    output logic [dsfr_pkg::ADDR_W-1:0] ram_rd_addr,
    input  logic [dsfr_pkg::BYTE_W-1:0] ram_rd_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dsfr_pkg::BYTE_W-1:0] m_data_byte,
    output logic                        m_last_byte,
    output dsfr_pkg::rd_status_t        status
);
    import dsfr_pkg::*;

    rd_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              at_last;

    assign out_free = !valid_reg || m_ready;
    assign at_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RD_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RD_IDLE: begin
                if (rd_start.start) begin
                    state_next = RD_FETCH;
                end
            end
            RD_FETCH: begin
                if (out_free && at_last) begin
                    state_next = RD_IDLE;
                end
            end
            default: begin
                state_next = RD_IDLE;
            end
        endcase
    end

    // read port, index and output register
    always_comb begin
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        data_next   = data_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !m_ready;
        unique case (state_reg)
            RD_IDLE: begin
                if (rd_start.start) begin
                    ram_rd_en = 1'b1;
                    idx_next  = '0;
                    cnt_next  = rd_start.count;
                end
            end
            RD_FETCH: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    data_next  = ram_rd_data;
                    last_next  = at_last;
                    if (!at_last) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg + ADDR_W'(1);
                        idx_next    = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid     = valid_reg;
    assign m_data_byte = data_reg;
    assign m_last_byte = last_reg;
    assign status.busy = (state_reg == RD_FETCH);

endmodule

[rtl/dle_stx_frame_receiver_unit.sv]
// top level of the dle/stx/etx frame receiver with xor block check
// depends on dsfr_pkg, dsfr_ram, dsfr_rx_fsm and dsfr_readout
//
// Received bytes enter on the s_ channel, one request per byte. While no frame is
// being read out, a byte is taken every cycle: the receive state machine decodes
// escape sequences, keeps the running xor and writes payload bytes into a 64 entry
// payload memory. When the check byte matches, input stalls (s_ready low) while the
// payload is read back through the single registered read port of that memory,
// one byte per cycle into the output register unless m_ready low holds a waiting
// output byte; s_ready stays low until the last byte is loaded. After the check
// byte the readout enters its fetch state and from there loads the first byte into
// the output register. The last byte carries m_last_byte. A bad check byte, an
// empty frame, an abort or an overflow give no output. Input is accepted again as
// soon as the last byte sits in the output register. The store needs no clearing
// after reset: only entries written in the current frame are read. The control
// codes are written through cfg_wr_en, cfg_index and cfg_wdata; the user must
// write them only while the block is idle, which the block itself does not
// enforce. An index beyond the end code is ignored.
module dle_stx_frame_receiver_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dsfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsfr_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dsfr_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dsfr_pkg::BYTE_W-1:0]    m_data_byte,
    output logic                           m_last_byte
);
    import dsfr_pkg::*;

    logic [BYTE_W-1:0] escape_reg;
    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] end_reg;
    logic              accept;
    ram_wr_t           ram_wr;
    rd_start_t         rd_start;
    rd_status_t        rd_status;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    // control code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= ESCAPE_RST;
            start_reg  <= START_RST;
            end_reg    <= END_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ESCAPE: escape_reg <= cfg_wdata;
                CFG_START:  start_reg  <= cfg_wdata;
                CFG_END:    end_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input is held off while the store is being read, so a payload write never
    // meets a readout read of the same frame
    assign s_ready = !rd_status.busy;
    assign accept  = s_valid && s_ready;

    dsfr_rx_fsm u_rx_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .escape_code (escape_reg),
        .start_code  (start_reg),
        .end_code    (end_reg),
        .ram_wr      (ram_wr),
        .rd_start    (rd_start)
    );

    // payload store
    dsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.wr_en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dsfr_readout u_readout (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_start    (rd_start),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_last_byte (m_last_byte),
        .status      (rd_status)
    );

`ifndef SYNTH
    // no payload write while a frame is being read out
    a_no_write_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.wr_en |-> !rd_status.busy)
        else $error("payload write during readout");

    // a good check byte starts the readout in the next cycle
    a_start_to_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_start.start |=> rd_status.busy)
        else $error("readout did not start");

    // a readout is only started for a non-empty frame and from idle
    a_start_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_start.start |-> (rd_start.count != '0) && !rd_status.busy)
        else $error("bad readout start");
`endif

endmodule
